// ----- hw/rtl/whtm_pkg.sv -----
package whtm_pkg;

    localparam int KEY_MAX_W = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [39:0] ONE_SECOND = 40'd16000000000;

    localparam logic [2:0] ST_MERGED   = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_DROPPED  = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;
    localparam logic [2:0] ST_HIT      = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    localparam logic [1:0] REG_RESOLUTION = 2'd0;
    localparam logic [1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_OFFSET     = 2'd2;
    localparam logic [1:0] REG_RECIP      = 2'd3;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_DEPOSIT,
        KIND_READ
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [2:0]            status;
        logic [7:0]            wire_no;
        logic [KEY_MAX_W-1:0]  key;
        logic [31:0]           energy;
        logic [23:0]           length;
        logic [39:0]           hit_time;
    } item_t;

endpackage

// ----- hw/rtl/whtm_front.sv -----
module whtm_front #(
    parameter int WIRE_COUNT  = 144,
    parameter int LAYER_COUNT = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 op,
    input  logic [2:0]           layer,
    input  logic signed [23:0]   pos_x,
    input  logic signed [23:0]   pos_y,
    input  logic [39:0]          entry_time,
    input  logic [39:0]          exit_time,
    input  logic [31:0]          deposit_energy,
    input  logic [23:0]          path_length,
    input  logic [7:0]           read_wire,
    input  logic signed [23:0]   wire_zero_offset,
    input  logic [23:0]          pitch_reciprocal,
    output logic                 push,
    output whtm_pkg::item_t      item,
    output logic                 front_busy
);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_CLS} fstate_t;

    fstate_t              state_reg;
    logic                 op_reg;
    logic [2:0]           layer_reg;
    logic [7:0]           rw_reg;
    logic [31:0]          e_reg;
    logic [23:0]          len_reg;
    logic [39:0]          t_reg;
    logic signed [24:0]   diff_reg;
    logic signed [49:0]   prod_reg;

    logic [40:0]          time_sum;
    logic signed [23:0]   pos_sel;
    logic signed [25:0]   wire_s;
    logic                 neg;
    logic                 big;
    logic [7:0]           w8;
    logic [7:0]           wsat;
    logic                 layer_ok;
    logic                 dep_ok;
    logic                 rd_ok;
    logic [7:0]           key_wire;

    assign time_sum = {1'b0, entry_time} + {1'b0, exit_time};
    assign pos_sel  = layer[0] ? pos_x : pos_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    state_reg <= F_CLS;
                end
                F_CLS:
                begin
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            layer_reg <= layer;
            rw_reg    <= read_wire;
            e_reg     <= deposit_energy;
            len_reg   <= path_length;
            t_reg     <= (exit_time > whtm_pkg::ONE_SECOND) ? entry_time : time_sum[40:1];
            diff_reg  <= {pos_sel[23], pos_sel} - {wire_zero_offset[23], wire_zero_offset};
        end
        if (state_reg == F_MUL)
        begin
            prod_reg <= diff_reg * $signed({1'b0, pitch_reciprocal});
        end
    end

    // floor division by 2^24 is the arithmetic shift
    always_comb
    begin
        wire_s   = prod_reg[49:24];
        neg      = wire_s[25];
        big      = |wire_s[24:8];
        w8       = wire_s[7:0];
        wsat     = neg ? 8'd0 : (big ? 8'd255 : w8);
        layer_ok = {1'b0, layer_reg} < 4'(LAYER_COUNT);
        dep_ok   = !neg && !big && (w8 != 8'd0) && ({1'b0, w8} <= 9'(WIRE_COUNT)) && layer_ok;
        rd_ok    = (rw_reg != 8'd0) && ({1'b0, rw_reg} <= 9'(WIRE_COUNT)) && layer_ok;
        key_wire = op_reg ? rw_reg : w8;

        item.kind     = whtm_pkg::KIND_DIRECT;
        item.status   = whtm_pkg::ST_RANGE;
        item.wire_no  = wsat;
        item.key      = whtm_pkg::KEY_MAX_W'(layer_reg) * whtm_pkg::KEY_MAX_W'(WIRE_COUNT)
                        + whtm_pkg::KEY_MAX_W'(key_wire) - whtm_pkg::KEY_MAX_W'(1);
        item.energy   = e_reg;
        item.length   = len_reg;
        item.hit_time = t_reg;
        if (op_reg)
        begin
            item.wire_no  = rw_reg;
            item.energy   = '0;
            item.length   = '0;
            item.hit_time = '0;
            if (rd_ok)
            begin
                item.kind = whtm_pkg::KIND_READ;
            end
        end
        else if (e_reg == 32'd0)
        begin
            item.status   = whtm_pkg::ST_ZERO;
            item.wire_no  = 8'd0;
            item.energy   = '0;
            item.length   = '0;
            item.hit_time = '0;
        end
        else if (dep_ok)
        begin
            item.kind = whtm_pkg::KIND_DEPOSIT;
        end
    end

    assign push       = (state_reg == F_CLS);
    assign front_busy = (state_reg != F_IDLE);

endmodule

// ----- hw/rtl/whtm_queue.sv -----
module whtm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  whtm_pkg::item_t  push_item,
    input  logic             pop,
    output whtm_pkg::item_t  head_item,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = $clog2(whtm_pkg::QUEUE_DEPTH);

    whtm_pkg::item_t     slots_reg [whtm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_reg;
    logic [PTR_W-1:0]    rd_reg;
    logic [PTR_W:0]      count_reg;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (PTR_W + 1)'(whtm_pkg::QUEUE_DEPTH));
    assign head_item = slots_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (PTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/whtm_back.sv -----
module whtm_back #(
    parameter int HITS_PER_WIRE = 16,
    parameter int WIRE_COUNT    = 144,
    parameter int LAYER_COUNT   = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  whtm_pkg::item_t  head_item,
    input  logic             q_empty,
    input  logic [19:0]      two_hit_resolution,
    input  logic [31:0]      energy_threshold,
    output logic             pop,
    output logic             clearing,
    output logic             done,
    output logic [2:0]       status,
    output logic [7:0]       wire_number,
    output logic [5:0]       slot,
    output logic [31:0]      hit_energy,
    output logic [23:0]      hit_length,
    output logic [39:0]      hit_time,
    output logic             last
);

    localparam int KEYS   = LAYER_COUNT * WIRE_COUNT;
    localparam int KEY_W  = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int SLOT_W = (HITS_PER_WIRE > 1) ? $clog2(HITS_PER_WIRE) : 1;
    localparam int CNT_W  = $clog2(HITS_PER_WIRE + 1);
    localparam int ADDR_W = KEY_W + SLOT_W;
    localparam int DEPTH  = KEYS * (2 ** SLOT_W);

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_COUNT, B_WALK_RD, B_WALK_CHK, B_SHIFT_RD, B_SHIFT_WR, B_INSERT
    } bstate_t;

    // hit word: time, length, energy
    logic [95:0]       hit_mem [DEPTH];
    logic [CNT_W-1:0]  cnt_mem [KEYS];
    logic [95:0]       hit_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;

    logic              hit_we;
    logic [ADDR_W-1:0] hit_waddr;
    logic [95:0]       hit_wdata;
    logic [ADDR_W-1:0] hit_raddr;
    logic              cnt_we;
    logic [KEY_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [KEY_W-1:0]  cnt_raddr;

    bstate_t           state_reg, state_next;
    logic [KEY_W:0]    clr_reg, clr_next;
    whtm_pkg::item_t   cur_reg, cur_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [6:0]        k_reg, k_next;
    logic              pend_reg, pend_next;
    logic [95:0]       pword_reg, pword_next;
    logic [5:0]        pslot_reg, pslot_next;
    logic              done_reg, done_next;
    logic [2:0]        status_reg, status_next;
    logic [7:0]        wire_reg, wire_next;
    logic [5:0]        slot_reg, slot_next;
    logic [95:0]       oword_reg, oword_next;
    logic              last_reg, last_next;

    logic [KEY_W-1:0]  key;
    logic [39:0]       ts;
    logic [23:0]       sl;
    logic [31:0]       se;
    logic [39:0]       dt;
    logic [32:0]       esum;
    logic [24:0]       lsum;
    logic [95:0]       own_word;
    logic              dep_end;
    logic [CNT_W-1:0]  dep_pos;

    always_ff @(posedge clk)
    begin
        if (hit_we)
        begin
            hit_mem[hit_waddr] <= hit_wdata;
        end
        hit_rd_reg <= hit_mem[hit_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    always_comb
    begin
        key      = cur_reg.key[KEY_W-1:0];
        ts       = hit_rd_reg[95:56];
        sl       = hit_rd_reg[55:32];
        se       = hit_rd_reg[31:0];
        dt       = (ts > cur_reg.hit_time) ? ts - cur_reg.hit_time : cur_reg.hit_time - ts;
        esum     = {1'b0, se} + {1'b0, cur_reg.energy};
        lsum     = {1'b0, sl} + {1'b0, cur_reg.length};
        own_word = {cur_reg.hit_time, cur_reg.length, cur_reg.energy};
        dep_end  = 1'b0;
        dep_pos  = i_reg;

        state_next  = state_reg;
        clr_next    = clr_reg;
        cur_next    = cur_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        pend_next   = pend_reg;
        pword_next  = pword_reg;
        pslot_next  = pslot_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        wire_next   = wire_reg;
        slot_next   = slot_reg;
        oword_next  = oword_reg;
        last_next   = last_reg;

        pop       = 1'b0;
        hit_we    = 1'b0;
        hit_waddr = {key, i_reg[SLOT_W-1:0]};
        hit_wdata = hit_rd_reg;
        hit_raddr = {key, i_reg[SLOT_W-1:0]};
        cnt_we    = 1'b0;
        cnt_waddr = key;
        cnt_wdata = '0;
        cnt_raddr = key;

        case (state_reg)
            B_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg[KEY_W-1:0];
                clr_next  = clr_reg + (KEY_W + 1)'(1);
                if (clr_reg == (KEY_W + 1)'(KEYS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                cnt_raddr = head_item.key[KEY_W-1:0];
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    cur_next  = head_item;
                    i_next    = '0;
                    k_next    = '0;
                    pend_next = 1'b0;
                    if (head_item.kind == whtm_pkg::KIND_DIRECT)
                    begin
                        done_next   = 1'b1;
                        status_next = head_item.status;
                        wire_next   = head_item.wire_no;
                        slot_next   = '0;
                        oword_next  = {head_item.hit_time, head_item.length, head_item.energy};
                        last_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = B_COUNT;
                    end
                end
            end
            B_COUNT:
            begin
                n_next = (cnt_rd_reg > CNT_W'(HITS_PER_WIRE)) ? CNT_W'(HITS_PER_WIRE)
                                                               : cnt_rd_reg;
                state_next = B_WALK_RD;
            end
            B_WALK_RD:
            begin
                if (i_reg < n_reg)
                begin
                    state_next = B_WALK_CHK;
                end
                else if (cur_reg.kind == whtm_pkg::KIND_DEPOSIT)
                begin
                    dep_end = 1'b1;
                    dep_pos = n_reg;
                end
                else
                begin
                    cnt_we     = 1'b1;
                    done_next  = 1'b1;
                    wire_next  = cur_reg.wire_no;
                    last_next  = 1'b1;
                    state_next = B_IDLE;
                    if (pend_reg)
                    begin
                        status_next = whtm_pkg::ST_HIT;
                        slot_next   = pslot_reg;
                        oword_next  = pword_reg;
                    end
                    else
                    begin
                        status_next = whtm_pkg::ST_EMPTY;
                        slot_next   = '0;
                        oword_next  = '0;
                    end
                end
            end
            B_WALK_CHK:
            begin
                if (cur_reg.kind == whtm_pkg::KIND_DEPOSIT)
                begin
                    if (dt < {20'd0, two_hit_resolution})
                    begin
                        hit_we    = 1'b1;
                        hit_wdata = {(ts > cur_reg.hit_time) ? cur_reg.hit_time : ts,
                                     lsum[24] ? 24'hFFFFFF : lsum[23:0],
                                     esum[32] ? 32'hFFFFFFFF : esum[31:0]};
                        done_next   = 1'b1;
                        status_next = whtm_pkg::ST_MERGED;
                        wire_next   = cur_reg.wire_no;
                        slot_next   = 6'(i_reg);
                        oword_next  = hit_wdata;
                        last_next   = 1'b1;
                        state_next  = B_IDLE;
                    end
                    else if (ts > cur_reg.hit_time)
                    begin
                        dep_end = 1'b1;
                        dep_pos = i_reg;
                    end
                    else
                    begin
                        i_next     = i_reg + CNT_W'(1);
                        state_next = B_WALK_RD;
                    end
                end
                else
                begin
                    if (se > energy_threshold)
                    begin
                        if (pend_reg)
                        begin
                            done_next   = 1'b1;
                            status_next = whtm_pkg::ST_HIT;
                            wire_next   = cur_reg.wire_no;
                            slot_next   = pslot_reg;
                            oword_next  = pword_reg;
                            last_next   = 1'b0;
                        end
                        pend_next  = 1'b1;
                        pword_next = hit_rd_reg;
                        pslot_next = k_reg[5:0];
                        k_next     = k_reg + 7'd1;
                    end
                    i_next     = i_reg + CNT_W'(1);
                    state_next = B_WALK_RD;
                end
            end
            B_SHIFT_RD:
            begin
                // i counts down from the fill level to the insert point
                hit_raddr = {key, SLOT_W'(i_reg - CNT_W'(1))};
                if (i_reg > pos_reg)
                begin
                    state_next = B_SHIFT_WR;
                end
                else
                begin
                    state_next = B_INSERT;
                end
            end
            B_SHIFT_WR:
            begin
                hit_we     = 1'b1;
                i_next     = i_reg - CNT_W'(1);
                state_next = B_SHIFT_RD;
            end
            B_INSERT:
            begin
                hit_we      = 1'b1;
                hit_waddr   = {key, pos_reg[SLOT_W-1:0]};
                hit_wdata   = own_word;
                cnt_we      = 1'b1;
                cnt_wdata   = n_reg + CNT_W'(1);
                done_next   = 1'b1;
                status_next = whtm_pkg::ST_INSERTED;
                wire_next   = cur_reg.wire_no;
                slot_next   = 6'(pos_reg);
                oword_next  = own_word;
                last_next   = 1'b1;
                state_next  = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (dep_end)
        begin
            if (n_reg >= CNT_W'(HITS_PER_WIRE))
            begin
                done_next   = 1'b1;
                status_next = whtm_pkg::ST_DROPPED;
                wire_next   = cur_reg.wire_no;
                slot_next   = '0;
                oword_next  = own_word;
                last_next   = 1'b1;
                state_next  = B_IDLE;
            end
            else
            begin
                pos_next   = dep_pos;
                i_next     = n_reg;
                state_next = B_SHIFT_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_CLEAR;
            clr_reg    <= '0;
            cur_reg    <= '0;
            n_reg      <= '0;
            i_reg      <= '0;
            pos_reg    <= '0;
            k_reg      <= '0;
            pend_reg   <= 1'b0;
            pword_reg  <= '0;
            pslot_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= '0;
            wire_reg   <= '0;
            slot_reg   <= '0;
            oword_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cur_reg    <= cur_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            pos_reg    <= pos_next;
            k_reg      <= k_next;
            pend_reg   <= pend_next;
            pword_reg  <= pword_next;
            pslot_reg  <= pslot_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            wire_reg   <= wire_next;
            slot_reg   <= slot_next;
            oword_reg  <= oword_next;
            last_reg   <= last_next;
        end
    end

    assign clearing    = (state_reg == B_CLEAR);
    assign done        = done_reg;
    assign status      = status_reg;
    assign wire_number = wire_reg;
    assign slot        = slot_reg;
    assign hit_time    = oword_reg[95:56];
    assign hit_length  = oword_reg[55:32];
    assign hit_energy  = oword_reg[31:0];
    assign last        = last_reg;

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CNT_W'(HITS_PER_WIRE))
        else $error("fill level beyond list size");

    a_hit_above_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == whtm_pkg::ST_HIT |-> oword_reg[31:0] > energy_threshold)
        else $error("hit at or below threshold read out");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CLEAR |-> !done_reg && !pop)
        else $error("activity during clearing pass");

endmodule

// ----- hw/rtl/wire_hit_time_merge_buffer_unit.sv -----
// wire hit time-merge buffer
// command channel: an item is taken at a clock edge with start high and busy low.
// op 0 deposits a step into the time-ordered hit list of its wire; op 1 reads
// out the hits of read_wire above the energy threshold and clears that list.
// results appear for one cycle each with done high; last marks the final one.
// the receiver cannot hold results off: every done cycle is a delivered result.
// config writes go in through cfg_valid/cfg_ready (always ready), cfg_index 0..3.
// front end: three steps (time and offset, multiply, classify), then a
// four-entry queue to the back end, which works on one request at a time.
// back end: a deposit walks the hits of its wire in time order and moves
// later hits up for an insert, one hit-memory port each way; a read walks
// all stored hits of its wire; rejected items are answered from idle.
// after reset the per-wire counts are cleared one wire a cycle, 1152 wires
// with the default sizes (LAYER_COUNT * WIRE_COUNT); busy is high meanwhile.
// config registers return to their reset values at reset.
module wire_hit_time_merge_buffer_unit #(
    parameter int HITS_PER_WIRE = 16,
    parameter int WIRE_COUNT    = 144,
    parameter int LAYER_COUNT   = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [2:0]          layer,
    input  logic signed [23:0]  pos_x,
    input  logic signed [23:0]  pos_y,
    input  logic [39:0]         entry_time,
    input  logic [39:0]         exit_time,
    input  logic [31:0]         deposit_energy,
    input  logic [23:0]         path_length,
    input  logic [7:0]          read_wire,
    output logic                done,
    output logic [2:0]          status,
    output logic [7:0]          wire_number,
    output logic [5:0]          slot,
    output logic [31:0]         hit_energy,
    output logic [23:0]         hit_length,
    output logic [39:0]         hit_time,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    logic [19:0]         resolution_reg;
    logic [31:0]         threshold_reg;
    logic signed [23:0]  offset_reg;
    logic [23:0]         recip_reg;

    logic                accept;
    logic                push;
    logic                pop;
    logic                front_busy;
    logic                q_empty;
    logic                q_full;
    logic                clearing;
    whtm_pkg::item_t     push_item;
    whtm_pkg::item_t     head_item;

    assign cfg_ready = 1'b1;
    assign busy      = front_busy || q_full || clearing;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= 20'd6400;
            threshold_reg  <= 32'd0;
            offset_reg     <= -24'sd47468;
            recip_reg      <= 24'd25801;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                whtm_pkg::REG_RESOLUTION: resolution_reg <= cfg_data[19:0];
                whtm_pkg::REG_THRESHOLD:  threshold_reg  <= cfg_data;
                whtm_pkg::REG_OFFSET:     offset_reg     <= cfg_data[23:0];
                whtm_pkg::REG_RECIP:      recip_reg      <= cfg_data[23:0];
                default:                  recip_reg      <= recip_reg;
            endcase
        end
    end

    whtm_front #(
        .WIRE_COUNT  (WIRE_COUNT),
        .LAYER_COUNT (LAYER_COUNT)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .op               (op),
        .layer            (layer),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .entry_time       (entry_time),
        .exit_time        (exit_time),
        .deposit_energy   (deposit_energy),
        .path_length      (path_length),
        .read_wire        (read_wire),
        .wire_zero_offset (offset_reg),
        .pitch_reciprocal (recip_reg),
        .push             (push),
        .item             (push_item),
        .front_busy       (front_busy)
    );

    whtm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    whtm_back #(
        .HITS_PER_WIRE (HITS_PER_WIRE),
        .WIRE_COUNT    (WIRE_COUNT),
        .LAYER_COUNT   (LAYER_COUNT)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head_item          (head_item),
        .q_empty            (q_empty),
        .two_hit_resolution (resolution_reg),
        .energy_threshold   (threshold_reg),
        .pop                (pop),
        .clearing           (clearing),
        .done               (done),
        .status             (status),
        .wire_number        (wire_number),
        .slot               (slot),
        .hit_energy         (hit_energy),
        .hit_length         (hit_length),
        .hit_time           (hit_time),
        .last               (last)
    );

endmodule
